@@ rtl/skq_pkg.sv @@
// Shared types, sizes and codes for the sorted key queue.
// No dependencies; every other file in the block imports this package.
package skq_pkg;

   localparam int CAPACITY = 16;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int MODE_W = 3;
   localparam int STATUS_W = 2;
   localparam int KEY_W = 32;
   localparam int TAG_W = 32;

   typedef logic signed [KEY_W-1:0] key_type;
   typedef logic [TAG_W-1:0] tag_type;
   typedef logic [MODE_W-1:0] mode_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [CNT_W-1:0] count_type;

   localparam mode_type MODE_APPEND = 3'd0;
   localparam mode_type MODE_PREPEND = 3'd1;
   localparam mode_type MODE_SORTED = 3'd2;
   localparam mode_type MODE_POP_HEAD = 3'd3;
   localparam mode_type MODE_POP_KEY = 3'd4;

   localparam status_type ST_DONE = 2'd0;
   localparam status_type ST_EMPTY = 2'd1;
   localparam status_type ST_NOT_FOUND = 2'd2;
   localparam status_type ST_FULL = 2'd3;

   localparam key_type KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
   localparam key_type KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};

   // per-cell update command
   typedef struct packed {
      logic load_new;
      logic take_left;
      logic take_right;
   } cell_ctl_type;

   // per-cell compare results against the broadcast key
   typedef struct packed {
      logic ge;
      logic le;
      logic eq;
   } cell_flag_type;

endpackage

@@ rtl/skq_req_if.sv @@
// Request channel of the sorted key queue: valid/ready plus operation payload.
// Depends on skq_pkg.
interface skq_req_if;
   import skq_pkg::*;

   logic valid;
   logic ready;
   mode_type mode;
   key_type key;
   tag_type item_tag;

   modport source (output valid, output mode, output key, output item_tag, input ready);
   modport sink (input valid, input mode, input key, input item_tag, output ready);
endinterface

@@ rtl/skq_rsp_if.sv @@
// Response channel of the sorted key queue: valid/ready plus result payload.
// Depends on skq_pkg.
interface skq_rsp_if;
   import skq_pkg::*;

   logic valid;
   logic ready;
   status_type status;
   tag_type out_tag;
   key_type out_key;
   count_type count;

   modport source (output valid, output status, output out_tag, output out_key,
                   output count, input ready);
   modport sink (input valid, input status, input out_tag, input out_key,
                 input count, output ready);
endinterface

@@ rtl/sorted_key_queue_top.sv @@
// Sorted key queue: top level with the cell chain, insert/remove control and
// the registered response. Depends on skq_pkg, skq_req_if, skq_rsp_if, skq_cell.
//
// Usage:
//   req_chan carries one operation per beat: append, prepend, sorted insert,
//   remove head or remove by key, with a key and a tag. rsp_chan returns
//   exactly one result beat per request: status, removed tag, removed or
//   inserted key and the entry count after the operation.
//   Each request is handled in the cycle it is accepted: all cells compare
//   the key in parallel, pick the insert or remove slot, and shift toward
//   or away from it in one step. The result appears on rsp_chan the cycle
//   after acceptance. One request per cycle is taken while the
//   response register is empty or being drained, so throughput is one item
//   per cycle; the single response register sets that bound.
//   If the receiver stalls, the result holds in the response register and
//   req_chan.ready drops until it is taken.
//   Reset (synchronous) empties the queue and clears the response valid;
//   req_chan.ready stays low while reset is high.
//   Slots beyond the count hold stale data and are never read.
module sorted_key_queue_top (
   input logic clock,
   input logic reset,
   skq_req_if.sink req_chan,
   skq_rsp_if.source rsp_chan
);
   import skq_pkg::*;

   count_type count_ff, count_in;
   logic rsp_valid_ff;
   status_type rsp_status_ff, rsp_status_in;
   tag_type rsp_tag_ff, rsp_tag_in;
   key_type rsp_key_ff, rsp_key_in;

   key_type cell_key [CAPACITY];
   tag_type cell_tag [CAPACITY];
   cell_flag_type cell_flags [CAPACITY];
   cell_ctl_type cell_ctl [CAPACITY];

   logic [CAPACITY-1:0] occ, last, ge, le, eq, ins_p, rem_q, hit;
   logic accept, empty, full;
   logic is_ins, is_rem, do_ins, do_rem, found;
   logic all_le;
   key_type tail_key, head_key, ins_key, hit_key;
   tag_type hit_tag;

   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !reset && (!rsp_valid_ff || rsp_chan.ready);
   assign empty = count_ff == '0;
   assign full = count_ff == CNT_W'(CAPACITY);
   assign head_key = cell_key[0];

   assign is_ins = req_chan.mode == MODE_APPEND || req_chan.mode == MODE_PREPEND ||
                   req_chan.mode == MODE_SORTED;
   assign is_rem = req_chan.mode == MODE_POP_HEAD || req_chan.mode == MODE_POP_KEY;

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         key_type rkey;
         tag_type rtag;
         logic ins_prev, rem_prev;

         assign occ[gi] = count_ff > CNT_W'(gi);
         assign ge[gi] = cell_flags[gi].ge;
         assign le[gi] = cell_flags[gi].le;
         assign eq[gi] = cell_flags[gi].eq;

         if (gi == 0) begin : g_first
            assign ins_prev = 1'b0;
            assign rem_prev = 1'b0;
         end else begin : g_rest
            assign ins_prev = ins_p[gi-1];
            assign rem_prev = rem_q[gi-1];
         end

         if (gi == CAPACITY - 1) begin : g_tail
            assign last[gi] = occ[gi];
            assign rkey = cell_key[gi];
            assign rtag = cell_tag[gi];
         end else begin : g_mid
            assign last[gi] = occ[gi] && !occ[gi+1];
            assign rkey = cell_key[gi+1];
            assign rtag = cell_tag[gi+1];
         end

         assign hit[gi] = rem_q[gi] && !rem_prev && occ[gi];
         assign cell_ctl[gi].load_new = do_ins && ins_p[gi] && !ins_prev;
         assign cell_ctl[gi].take_left = do_ins && ins_prev;
         assign cell_ctl[gi].take_right = do_rem && rem_q[gi];

         skq_cell u_cell (
            .clock     (clock),
            .ctl       (cell_ctl[gi]),
            .cmp_key   (req_chan.key),
            .new_key   (ins_key),
            .new_tag   (req_chan.item_tag),
            .left_key  ((gi == 0) ? ins_key : cell_key[(gi == 0) ? 0 : gi-1]),
            .left_tag  ((gi == 0) ? req_chan.item_tag : cell_tag[(gi == 0) ? 0 : gi-1]),
            .right_key (rkey),
            .right_tag (rtag),
            .key_q     (cell_key[gi]),
            .tag_q     (cell_tag[gi]),
            .flags     (cell_flags[gi])
         );
      end
   endgenerate

   // gather tail entry, removed entry and the "key at least tail" test
   always_comb begin
      tail_key = '0;
      hit_key = '0;
      hit_tag = '0;
      all_le = 1'b1;
      for (int i = 0; i < CAPACITY; i++) begin
         tail_key = tail_key | ({KEY_W{last[i]}} & cell_key[i]);
         hit_key = hit_key | ({KEY_W{hit[i]}} & cell_key[i]);
         hit_tag = hit_tag | ({TAG_W{hit[i]}} & cell_tag[i]);
         all_le = all_le && (!occ[i] || le[i]);
      end
   end

   // new key and the insert thermometer: ones from the insert slot upward
   always_comb begin
      ins_key = req_chan.key;
      ins_p = '0;
      if (req_chan.mode == MODE_APPEND) begin
         ins_key = empty ? '0 : ((tail_key == KEY_MAX) ? tail_key : tail_key + key_type'(1));
         ins_p = ~occ;
      end else if (req_chan.mode == MODE_PREPEND) begin
         ins_key = empty ? '0 : ((head_key == KEY_MIN) ? head_key : head_key - key_type'(1));
         ins_p = '1;
      end else if (empty || ge[0]) begin
         ins_p = '1;
      end else if (all_le) begin
         ins_p = ~occ;
      end else begin
         ins_p = ~occ | ge;
      end
   end

   // remove thermometer: ones from the removed slot upward
   always_comb begin
      if (req_chan.mode == MODE_POP_HEAD) begin
         rem_q = '1;
         found = !empty;
      end else begin
         rem_q = occ & ge;
         found = |(hit & eq);
      end
   end

   assign do_ins = accept && is_ins && !full;
   assign do_rem = accept && is_rem && !empty && found;

   always_comb begin
      count_in = count_ff;
      rsp_status_in = ST_DONE;
      rsp_tag_in = '0;
      rsp_key_in = '0;
      if (is_ins) begin
         if (full) begin
            rsp_status_in = ST_FULL;
         end else begin
            count_in = count_ff + count_type'(1);
            rsp_key_in = ins_key;
         end
      end else if (is_rem) begin
         if (empty) begin
            rsp_status_in = ST_EMPTY;
         end else if (!found) begin
            rsp_status_in = ST_NOT_FOUND;
         end else begin
            count_in = count_ff - count_type'(1);
            rsp_tag_in = hit_tag;
            rsp_key_in = hit_key;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // hold the result until taken
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= rsp_status_in;
         rsp_tag_ff <= rsp_tag_in;
         rsp_key_ff <= rsp_key_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.status = rsp_status_ff;
   assign rsp_chan.out_tag = rsp_tag_ff;
   assign rsp_chan.out_key = rsp_key_ff;
   assign rsp_chan.count = count_ff;

   logic order_ok;
   always_comb begin
      order_ok = 1'b1;
      for (int i = 0; i < CAPACITY - 1; i++) begin
         if (occ[i+1] && cell_key[i] > cell_key[i+1]) begin
            order_ok = 1'b0;
         end
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_sorted: assert property (@(posedge clock) disable iff (reset)
      order_ok)
      else $error("occupied cells out of key order");

   a_ins_count: assert property (@(posedge clock) disable iff (reset)
      do_ins |=> count_ff == $past(count_ff) + count_type'(1))
      else $error("insert did not grow the count");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted beat produced no response");

endmodule

@@ rtl/skq_cell.sv @@
// One slot of the sorted key chain: holds a key and tag, compares against the
// broadcast key and loads from the new entry or a neighbor. Depends on skq_pkg.
module skq_cell (
   input  logic                 clock,
   input  skq_pkg::cell_ctl_type ctl,
   input  skq_pkg::key_type     cmp_key,
   input  skq_pkg::key_type     new_key,
   input  skq_pkg::tag_type     new_tag,
   input  skq_pkg::key_type     left_key,
   input  skq_pkg::tag_type     left_tag,
   input  skq_pkg::key_type     right_key,
   input  skq_pkg::tag_type     right_tag,
   output skq_pkg::key_type     key_q,
   output skq_pkg::tag_type     tag_q,
   output skq_pkg::cell_flag_type flags
);
   import skq_pkg::*;

   key_type key_ff, key_in;
   tag_type tag_ff, tag_in;

   always_comb begin
      key_in = key_ff;
      tag_in = tag_ff;
      if (ctl.load_new) begin
         key_in = new_key;
         tag_in = new_tag;
      end else if (ctl.take_left) begin
         key_in = left_key;
         tag_in = left_tag;
      end else if (ctl.take_right) begin
         key_in = right_key;
         tag_in = right_tag;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      tag_ff <= tag_in;
   end

   assign flags.ge = key_ff >= cmp_key;
   assign flags.le = key_ff <= cmp_key;
   assign flags.eq = key_ff == cmp_key;
   assign key_q = key_ff;
   assign tag_q = tag_ff;

endmodule
